/* hdl/sal_pkg.sv */
// Package for the sorted array list: field widths, operation and status codes,
// and the control word broadcast from the top level to the row of cells.
// No dependencies.
`default_nettype none

package sal_pkg;

   localparam int DATA_W       = 32;
   localparam int FUNC_W       = 3;
   localparam int STATUS_W     = 2;
   localparam int CAPACITY_DEF = 64;

   // Operation codes carried in the request word.
   localparam logic [FUNC_W-1:0] OP_INSERT = 3'd0;
   localparam logic [FUNC_W-1:0] OP_DELETE = 3'd1;
   localparam logic [FUNC_W-1:0] OP_LOOKUP = 3'd2;
   localparam logic [FUNC_W-1:0] OP_READ   = 3'd3;
   localparam logic [FUNC_W-1:0] OP_REWIND = 3'd4;

   // Status codes carried in the response word.
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd3;

   // Control word shared by every cell in the row.
   typedef struct packed {
      logic                     capture;   // register compare flags this cycle
      logic                     ins;       // open a gap and place put_value
      logic                     del;       // close the gap at the first match
      logic signed [DATA_W-1:0] cmp_value; // operand of the compare phase
      logic signed [DATA_W-1:0] put_value; // value written by an insert
   } cell_ctl_type;

endpackage

`default_nettype wire

/* hdl/sal_cell.sv */
// One place of the sorted list: holds an entry and its compare flags.
// Depends on sal_pkg; instanced in a row by sorted_array_list.
`default_nettype none

module sal_cell
   import sal_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int IDX_W = 6,
   parameter int CNT_W = 7
) (
   input  wire logic                     clock,
   input  wire cell_ctl_type             ctl,
   input  wire logic [CNT_W-1:0]         count,
   input  wire logic [IDX_W-1:0]         cursor,
   input  wire logic signed [DATA_W-1:0] left_entry,
   input  wire logic                     left_ge,
   input  wire logic signed [DATA_W-1:0] right_entry,
   output logic signed [DATA_W-1:0]      entry,
   output logic                          ge,
   output logic                          hit,
   output logic [DATA_W-1:0]             rd_data
);

   logic signed [DATA_W-1:0] entry_ff;
   logic                     ge_ff;
   logic                     eq_ff;
   logic                     end_ff;
   logic                     sel_ff;
   logic                     occupied;

   assign occupied = count > CNT_W'(INDEX);

   // Compare phase: note where this place stands against the operand.
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         ge_ff  <= occupied && (ctl.cmp_value <= entry_ff);
         eq_ff  <= occupied && (ctl.cmp_value == entry_ff);
         end_ff <= count == CNT_W'(INDEX);
         sel_ff <= cursor == IDX_W'(INDEX);
      end
   end

   // Apply phase: an insert moves the entries not below the new value up one place, a delete
   // pulls the entries from the first match onwards down one place.
   always_ff @(posedge clock) begin
      if (ctl.ins) begin
         if (left_ge) begin
            entry_ff <= left_entry;
         end else if (ge_ff || end_ff) begin
            entry_ff <= ctl.put_value;
         end
      end else if (ctl.del && ge_ff) begin
         entry_ff <= right_entry;
      end
   end

   assign entry   = entry_ff;
   assign ge      = ge_ff;
   assign hit     = eq_ff;
   assign rd_data = sel_ff ? entry_ff : '0;

endmodule

`default_nettype wire

/* hdl/sorted_array_list.sv */
// Top level of the sorted array list: request decode, count and cursor, and
// the row of sal_cell places. Depends on sal_pkg and sal_cell.
//
//   channel   direction  handshake                 payload
//   request   in         start high, busy low      req_func, req_value
//   response  out        rsp_strobe, one cycle     rsp_status, rsp_found,
//                                                  rsp_value_out, rsp_count,
//                                                  rsp_is_empty, rsp_is_full
//
// For each request, at the accepting edge each cell registers
// how its entry compares with the operand, and at the next edge all cells
// shift together and the response word is registered. busy is high for the
// one cycle in between, so a new request can be taken in the cycle that shows
// the response. Synchronous reset empties the list and clears the cursor; the
// entries themselves are not cleared. The receiver cannot stall responses.
`default_nettype none

module sorted_array_list
   import sal_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int IDX_W    = $clog2(CAPACITY),
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [FUNC_W-1:0]        req_func,
   input  wire logic signed [DATA_W-1:0] req_value,
   output logic                          rsp_strobe,
   output logic [STATUS_W-1:0]           rsp_status,
   output logic                          rsp_found,
   output logic signed [DATA_W-1:0]      rsp_value_out,
   output logic [CNT_W-1:0]              rsp_count,
   output logic                          rsp_is_empty,
   output logic                          rsp_is_full
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_APPLY = 2'b10
   } state_type;

   state_type                state_ff, state_in;
   logic [FUNC_W-1:0]        op_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         cursor_ff, cursor_in;
   logic [IDX_W-1:0]         eff_cur_ff, eff_cur_in;
   logic                     strobe_ff;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic                     found_ff, found_in;
   logic [DATA_W-1:0]        vout_ff, vout_in;
   logic [CNT_W-1:0]         rcount_ff;

   logic                     accept;
   logic                     list_full;
   logic                     list_empty;
   logic                     found;
   logic [DATA_W-1:0]        rd_word;
   logic [CNT_W-1:0]         last_pos;
   cell_ctl_type             ctl;

   logic signed [DATA_W-1:0] entry_vec [CAPACITY];
   logic [CAPACITY-1:0]      ge_vec;
   logic [CAPACITY-1:0]      hit_vec;
   logic [DATA_W-1:0]        rd_vec   [CAPACITY];

   assign busy       = state_ff == ST_APPLY;
   assign accept     = start && !busy;
   assign list_full  = count_ff == CNT_W'(CAPACITY);
   assign list_empty = count_ff == '0;
   assign found      = |hit_vec;
   assign last_pos   = count_ff - 1'b1;

   // A cursor left at or beyond the end starts again from the first place.
   assign eff_cur_in = (CNT_W'(cursor_ff) >= count_ff) ? '0 : cursor_ff;

   // Only one cell drives a non-zero read word, so an OR gathers it.
   always_comb begin
      rd_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_word = rd_word | rd_vec[i];
      end
   end

   // State decode, and apply-phase decode of the operation held from the request word.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      status_in     = STATUS_OK;
      found_in      = 1'b0;
      vout_in       = '0;
      ctl.capture   = accept;
      ctl.ins       = 1'b0;
      ctl.del       = 1'b0;
      ctl.cmp_value = req_value;
      ctl.put_value = value_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            state_in = ST_IDLE;
            case (op_ff)
               OP_INSERT: begin
                  if (list_full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     ctl.ins  = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end
               OP_DELETE, OP_LOOKUP: begin
                  if (list_empty) begin
                     status_in = STATUS_EMPTY;
                  end else if (found) begin
                     found_in = 1'b1;
                     if (op_ff == OP_DELETE) begin
                        ctl.del  = 1'b1;
                        count_in = count_ff - 1'b1;
                     end
                  end else begin
                     status_in = STATUS_NOTFOUND;
                  end
               end
               OP_READ: begin
                  if (list_empty) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     vout_in   = rd_word;
                     cursor_in = (eff_cur_ff == last_pos[IDX_W-1:0]) ? '0
                                                                     : eff_cur_ff + 1'b1;
                  end
               end
               OP_REWIND: begin
                  cursor_in = '0;
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         cursor_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
         strobe_ff <= busy;
      end
   end

   // Request word held for the apply phase.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_func;
         value_ff   <= req_value;
         eff_cur_ff <= eff_cur_in;
      end
   end

   // Response word, loaded at the end of the apply phase.
   always_ff @(posedge clock) begin
      if (busy) begin
         status_ff <= status_in;
         found_ff  <= found_in;
         vout_ff   <= vout_in;
         rcount_ff <= count_in;
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_status    = status_ff;
   assign rsp_found     = found_ff;
   assign rsp_value_out = vout_ff;
   assign rsp_count     = rcount_ff;
   assign rsp_is_empty  = rcount_ff == '0;
   assign rsp_is_full   = rcount_ff == CNT_W'(CAPACITY);

   // The row of places, each wired to its neighbours on either side where it has one.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [DATA_W-1:0] left_entry;
      logic                     left_ge;
      logic signed [DATA_W-1:0] right_entry;

      if (g == 0) begin : g_first
         assign left_entry = entry_vec[g];
         assign left_ge    = 1'b0;
      end else begin : g_inner
         assign left_entry = entry_vec[g-1];
         assign left_ge    = ge_vec[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_entry = entry_vec[g];
      end else begin : g_body
         assign right_entry = entry_vec[g+1];
      end

      sal_cell #(
         .INDEX (g),
         .IDX_W (IDX_W),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .count       (count_ff),
         .cursor      (eff_cur_in),
         .left_entry  (left_entry),
         .left_ge     (left_ge),
         .right_entry (right_entry),
         .entry       (entry_vec[g]),
         .ge          (ge_vec[g]),
         .hit         (hit_vec[g]),
         .rd_data     (rd_vec[g])
      );
   end

endmodule

`default_nettype wire

/* hdl/sal_checker.sv */
// Port-level checks for sorted_array_list, attached to it by bind.
// Depends on sal_pkg and on the top level's port names.
`default_nettype none

module sal_checker
   import sal_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     start,
   input wire logic                     busy,
   input wire logic                     rsp_strobe,
   input wire logic [STATUS_W-1:0]      rsp_status,
   input wire logic                     rsp_found,
   input wire logic [CNT_W-1:0]         rsp_count,
   input wire logic                     rsp_is_empty,
   input wire logic                     rsp_is_full
);

   // Every accepted word is followed by busy and then by its response strobe.
   a_answer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy ##1 rsp_strobe)
      else $error("accepted word not answered after two cycles");

   // Responses never come in consecutive cycles.
   a_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two responses in consecutive cycles");

   // The empty flag agrees with the reported count.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_is_empty == (rsp_count == '0)))
      else $error("empty flag disagrees with count");

   // A refused insert is only reported on a full list.
   a_refused: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == STATUS_FULL) |-> rsp_is_full)
      else $error("insert refused while list not full");

   // A match always comes with a good status.
   a_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_found) |-> rsp_status == STATUS_OK)
      else $error("found reported with a failing status");

endmodule

bind sorted_array_list sal_checker #(
   .CAPACITY (CAPACITY),
   .CNT_W    (CNT_W)
) u_sal_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_strobe   (rsp_strobe),
   .rsp_status   (rsp_status),
   .rsp_found    (rsp_found),
   .rsp_count    (rsp_count),
   .rsp_is_empty (rsp_is_empty),
   .rsp_is_full  (rsp_is_full)
);

`default_nettype wire

/* sim/sorted_array_list_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for sorted_array_list: a shadow copy of the sorted
// list predicts every response word, which is compared field by field.
// Depends on sal_pkg and the sorted_array_list RTL.

module sorted_array_list_tb
   import sal_pkg::*;
;

   localparam int CNT_W = $clog2(CAPACITY_DEF + 1);

   // One response word as the block reports it.
   typedef struct {
      logic [STATUS_W-1:0]      status;
      logic                     found;
      logic signed [DATA_W-1:0] value_out;
      logic [CNT_W-1:0]         count;
      logic                     is_empty;
      logic                     is_full;
   } list_response_type;

   // Shadow of the sorted list: applies each accepted request word to its own
   // copy of the entries, count and cursor, and queues the response it expects.
   class list_shadow;
      logic signed [DATA_W-1:0] entries [CAPACITY_DEF];
      int unsigned              held;
      int unsigned              cursor;
      int unsigned              mismatches;
      list_response_type        pending [$];

      function new();
         held       = 0;
         cursor     = 0;
         mismatches = 0;
      endfunction

      function void note_request(logic [FUNC_W-1:0] func,
                                 logic signed [DATA_W-1:0] value);
         list_response_type r;
         int                i;
         int                pos;
         r.status    = STATUS_OK;
         r.found     = 1'b0;
         r.value_out = '0;
         pos         = -1;
         case (func)
            OP_INSERT: begin
               if (held == CAPACITY_DEF) begin
                  r.status = STATUS_FULL;
               end else begin
                  // Move every entry not below the new value up one place.
                  i = held;
                  while (i > 0 && value <= entries[i-1]) begin
                     entries[i] = entries[i-1];
                     i--;
                  end
                  entries[i] = value;
                  held++;
               end
            end
            OP_DELETE, OP_LOOKUP: begin
               if (held == 0) begin
                  r.status = STATUS_EMPTY;
               end else begin
                  // Any equal entry will do: removing one of a run of equal
                  // values leaves the same list.
                  for (i = 0; i < held && pos < 0; i++)
                     if (entries[i] == value) pos = i;
                  if (pos < 0) begin
                     r.status = STATUS_NOTFOUND;
                  end else begin
                     r.found = 1'b1;
                     if (func == OP_DELETE) begin
                        for (i = pos; i + 1 < held; i++) entries[i] = entries[i+1];
                        held--;
                     end
                  end
               end
            end
            OP_READ: begin
               if (held == 0) begin
                  r.status = STATUS_EMPTY;
               end else begin
                  // A cursor left past the end by a delete starts again at 0.
                  if (cursor >= held) cursor = 0;
                  r.value_out = entries[cursor];
                  cursor = (cursor == held - 1) ? 0 : cursor + 1;
               end
            end
            OP_REWIND: begin
               cursor = 0;
            end
            default: begin
            end
         endcase
         r.count    = CNT_W'(held);
         r.is_empty = (held == 0);
         r.is_full  = (held == CAPACITY_DEF);
         pending.push_back(r);
      endfunction

      function void compare_field(string name, logic signed [DATA_W-1:0] want,
                                  logic signed [DATA_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(list_response_type got);
         list_response_type want;
         if (pending.size() == 0) begin
            $error("response word with no request outstanding");
            mismatches++;
         end else begin
            want = pending.pop_front();
            compare_field("status", DATA_W'(want.status), DATA_W'(got.status));
            compare_field("found", DATA_W'(want.found), DATA_W'(got.found));
            compare_field("value_out", want.value_out, got.value_out);
            compare_field("count", DATA_W'(want.count), DATA_W'(got.count));
            compare_field("is_empty", DATA_W'(want.is_empty), DATA_W'(got.is_empty));
            compare_field("is_full", DATA_W'(want.is_full), DATA_W'(got.is_full));
         end
      endfunction

      // A value currently held, so that deletes and lookups hit.
      function logic signed [DATA_W-1:0] pick_held();
         if (held == 0) return $urandom;
         return entries[$urandom_range(0, held - 1)];
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [FUNC_W-1:0]        req_func;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_strobe;
   logic [STATUS_W-1:0]      rsp_status;
   logic                     rsp_found;
   logic signed [DATA_W-1:0] rsp_value_out;
   logic [CNT_W-1:0]         rsp_count;
   logic                     rsp_is_empty;
   logic                     rsp_is_full;

   list_shadow book = new();
   int         max_gap;

   sorted_array_list dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_found     (rsp_found),
      .rsp_value_out (rsp_value_out),
      .rsp_count     (rsp_count),
      .rsp_is_empty  (rsp_is_empty),
      .rsp_is_full   (rsp_is_full)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watch both channels at each rising edge.
   always @(posedge clock) begin
      list_response_type got;
      if (!reset) begin
         if (start && !busy) book.note_request(req_func, req_value);
         if (rsp_strobe) begin
            got.status    = rsp_status;
            got.found     = rsp_found;
            got.value_out = rsp_value_out;
            got.count     = rsp_count;
            got.is_empty  = rsp_is_empty;
            got.is_full   = rsp_is_full;
            book.check_response(got);
         end
      end
   end

   // Present one request word after a random gap and hold it until taken.
   // start stays high when the next word follows with no gap.
   task automatic send_word(input logic [FUNC_W-1:0] func,
                            input logic signed [DATA_W-1:0] value);
      int gap;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_func  <= func;
      req_value <= value;
      do @(posedge clock); while (busy);
   endtask

   // Hold off the sender until every outstanding response has come back.
   task automatic wait_for_responses();
      start <= 1'b0;
      @(posedge clock);
      while (book.pending.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Operand mix: extremes, random words, held values and a small range, so duplicates and hits are common.
   function automatic logic signed [DATA_W-1:0] draw_value();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      if (pick < 4) return $urandom;
      if (pick < 6) return book.pick_held();
      return int'($urandom_range(0, 40)) - 20;
   endfunction

   task automatic send_random_word(input int ins_pct, input int del_pct);
      int unsigned roll;
      int unsigned kind;
      roll = $urandom_range(0, 99);
      kind = $urandom_range(0, 19);
      if (roll < ins_pct)
         send_word(OP_INSERT, draw_value());
      else if (roll < ins_pct + del_pct)
         send_word(OP_DELETE, $urandom_range(0, 1) ? book.pick_held() : draw_value());
      else if (kind < 8)
         send_word(OP_LOOKUP, $urandom_range(0, 1) ? book.pick_held() : draw_value());
      else if (kind < 16)
         send_word(OP_READ, $urandom);
      else if (kind < 18)
         send_word(OP_REWIND, $urandom);
      else
         send_word(FUNC_W'($urandom_range(5, 7)), $urandom);
   endtask

   initial begin
      int n;
      reset     <= 1'b1;
      start     <= 1'b0;
      req_func  <= OP_INSERT;
      req_value <= '0;
      max_gap   = 6;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty list, unused codes, extreme values, duplicates,
      // misses, rewind and a cursor stranded past the end by a delete.
      send_word(OP_READ, 32'sd7);
      send_word(OP_DELETE, 32'sd0);
      send_word(OP_LOOKUP, 32'sd5);
      send_word(OP_REWIND, 32'sd0);
      send_word(FUNC_W'(5), 32'h5555_5555);
      send_word(FUNC_W'(6), 32'haaaa_aaaa);
      send_word(FUNC_W'(7), 32'hffff_ffff);
      send_word(OP_INSERT, 32'h7fff_ffff);
      send_word(OP_INSERT, 32'h8000_0000);
      send_word(OP_INSERT, 32'sd0);
      send_word(OP_INSERT, -32'sd1);
      send_word(OP_INSERT, 32'sd0);
      send_word(OP_LOOKUP, 32'sd0);
      send_word(OP_LOOKUP, 32'sd1);
      send_word(OP_DELETE, 32'sd12345);
      repeat (4) send_word(OP_READ, 32'sd0);
      send_word(OP_DELETE, 32'h7fff_ffff);
      send_word(OP_READ, 32'sd0);
      send_word(OP_REWIND, 32'sd0);
      send_word(OP_READ, 32'sd0);
      send_word(OP_DELETE, 32'sd0);

      // Random part: alternate filling and draining phases, some with no
      // gaps at all, with one complete fill to full and drain to empty.
      for (int phase = 0; phase < 8; phase++) begin
         max_gap = (phase % 3 == 2) ? 0 : 6;
         for (n = 0; n < 80; n++) begin
            if (phase % 2 == 0) send_random_word(60, 15);
            else send_random_word(20, 55);
         end
         if (phase == 3) begin
            wait_for_responses();
            max_gap = 2;
            while (book.held < CAPACITY_DEF) send_word(OP_INSERT, draw_value());
            repeat (3) send_word(OP_INSERT, draw_value());
            send_word(OP_READ, 32'sd0);
            wait_for_responses();
            while (book.held > 0) send_word(OP_DELETE, book.pick_held());
            send_word(OP_READ, 32'sd0);
            send_word(OP_DELETE, draw_value());
         end
      end
      start <= 1'b0;

      for (n = 0; n < 1000 && book.pending.size() != 0; n++) @(posedge clock);
      repeat (4) @(posedge clock);
      if (book.pending.size() != 0)
         $error("%0d response words never arrived", book.pending.size());
      if (book.mismatches == 0 && book.pending.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #1_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
